[hdl/assert_macros.svh]
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion macros shared by the RTL; they compile away when SYNTH is defined.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH

// concurrent check, disabled while reset is low
`define ASSERT_PROP(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) prop) else $error(msg);

// concurrent check that is also active during reset
`define ASSERT_PROP_ALL(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`else

`define ASSERT_PROP(lbl, clk, rstn, prop, msg)
`define ASSERT_PROP_ALL(lbl, clk, prop, msg)

`endif

`endif

[hdl/mdsr_pkg.sv]
// ----------------------------------------------------------------------------
// mdsr_pkg
// Types, constants and the microcode program of the degree shift register.
// ----------------------------------------------------------------------------
package mdsr_pkg;

    // default register length
    localparam int MAX_LENGTH_DEF = 16;

    // configuration port
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;

    // pattern loaded on a reset edge and on a seed write
    localparam logic [7:0] LOAD_PATTERN = 8'hA5;

    // configuration reset values
    localparam logic [4:0]         STEP_LENGTH_RST = 5'd8;
    localparam logic [3:0]         CLASS_COUNT_RST = 4'd7;
    localparam logic signed [15:0] LEVEL_RST       = 16'sd4096;
    localparam logic [31:0]        GEN_RST         = 32'd1;

    // clamps
    localparam logic [3:0] CLASS_MAX = 4'd12;
    localparam logic [2:0] OCT_MAX   = 3'd4;

    // register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_STEP_LENGTH        = 3'd0,
        CFG_FLIP_THRESHOLD     = 3'd1,
        CFG_OCTAVE_COUNT       = 3'd2,
        CFG_SCALE_DEGREE_COUNT = 3'd3,
        CFG_OUTPUT_LEVEL       = 3'd4,
        CFG_SEED_VALUE         = 3'd5
    } t_cfg_idx;

    // datapath operations
    typedef enum logic [2:0] {
        OP_LATCH,
        OP_ROTATE,
        OP_MUL,
        OP_DIV,
        OP_MOD_END,
        OP_FRAC_END,
        OP_CV_START,
        OP_OUT
    } t_op;

    // sequencing conditions
    typedef enum logic [1:0] {
        C_WAIT_IN,
        C_JUMP,
        C_LOOP,
        C_WAIT_OUT
    } t_cond;

    localparam int PC_W = 4;
    typedef logic [PC_W-1:0] t_pc;

    // program steps
    localparam t_pc STEP_LATCH    = 4'd0;
    localparam t_pc STEP_ROTATE   = 4'd1;
    localparam t_pc STEP_MUL      = 4'd2;
    localparam t_pc STEP_MOD_DIV  = 4'd3;
    localparam t_pc STEP_MOD_END  = 4'd4;
    localparam t_pc STEP_FRAC_DIV = 4'd5;
    localparam t_pc STEP_FRAC_END = 4'd6;
    localparam t_pc STEP_CV_START = 4'd7;
    localparam t_pc STEP_CV_DIV   = 4'd8;
    localparam t_pc STEP_OUT      = 4'd9;

    // one control word
    typedef struct packed {
        t_op   op;
        t_cond cond;
        t_pc   target;
    } t_ucode;

    // control store
    function automatic t_ucode ucode_rom(input t_pc pc);
        t_ucode w;
        case (pc)
            STEP_LATCH:    w = '{op: OP_LATCH,    cond: C_WAIT_IN,  target: STEP_ROTATE};
            STEP_ROTATE:   w = '{op: OP_ROTATE,   cond: C_JUMP,     target: STEP_MUL};
            STEP_MUL:      w = '{op: OP_MUL,      cond: C_JUMP,     target: STEP_MOD_DIV};
            STEP_MOD_DIV:  w = '{op: OP_DIV,      cond: C_LOOP,     target: STEP_MOD_DIV};
            STEP_MOD_END:  w = '{op: OP_MOD_END,  cond: C_JUMP,     target: STEP_FRAC_DIV};
            STEP_FRAC_DIV: w = '{op: OP_DIV,      cond: C_LOOP,     target: STEP_FRAC_DIV};
            STEP_FRAC_END: w = '{op: OP_FRAC_END, cond: C_JUMP,     target: STEP_CV_START};
            STEP_CV_START: w = '{op: OP_CV_START, cond: C_JUMP,     target: STEP_CV_DIV};
            STEP_CV_DIV:   w = '{op: OP_DIV,      cond: C_LOOP,     target: STEP_CV_DIV};
            STEP_OUT:      w = '{op: OP_OUT,      cond: C_WAIT_OUT, target: STEP_LATCH};
            default:       w = '{op: OP_DIV,      cond: C_JUMP,     target: STEP_LATCH};
        endcase
        return w;
    endfunction

endpackage

[hdl/mutating_degree_shift_register_top.sv]
// ----------------------------------------------------------------------------
// mutating_degree_shift_register_top
// Looping random shift register sequencer that reports scale degrees.
//
// Each input transaction is one sample tick with clock and reset levels. A
// rising reset level reloads 0xA5 masked to the step length; a rising clock
// level rotates the register left, the recycled top bit inverted when an
// xorshift32 draw is below the flip threshold. Each tick gives one output
// transaction: register, degree, gate, trigger, bipolar CV and normalized
// degree. A microcoded sequencer drives one shared restoring divider that
// makes one quotient bit per cycle and is used three times per tick (degree
// modulo, degree fraction, CV). The result sits in an output register, so
// the next tick is taken while it waits. Configuration writes take effect
// at once; a seed write also reloads the register with 0xA5.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module mutating_degree_shift_register_top #(
    parameter int MAX_LENGTH = mdsr_pkg::MAX_LENGTH_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    // input channel
    input  logic                             i_in_valid,
    output logic                             o_in_ready,
    input  logic                             i_clock_high,
    input  logic                             i_reset_high,
    // output channel
    output logic                             o_out_valid,
    input  logic                             i_out_ready,
    output logic [15:0]                      o_register_bits,
    output logic [5:0]                       o_scale_degree,
    output logic signed [15:0]               o_gate_value,
    output logic signed [15:0]               o_trigger_value,
    output logic signed [15:0]               o_bipolar_cv,
    output logic [15:0]                      o_degree_fraction,
    // configuration port
    input  logic                             i_cfg_wr_en,
    input  logic [mdsr_pkg::CFG_IDX_W-1:0]   i_cfg_addr,
    input  logic [mdsr_pkg::CFG_DATA_W-1:0]  i_cfg_wdata
);

    localparam int DIV_STEPS = (MAX_LENGTH > 16) ? MAX_LENGTH : 16;
    localparam int CNT_W     = $clog2(DIV_STEPS);
    localparam int DIVR_W    = (MAX_LENGTH + 1 > 7) ? MAX_LENGTH + 1 : 7;
    localparam int NUM_W     = (MAX_LENGTH + 17 > 23) ? MAX_LENGTH + 17 : 23;
    localparam int DIFF_W    = MAX_LENGTH + 2;
    localparam int PROD_W    = MAX_LENGTH + 18;
    localparam int MAG_W     = MAX_LENGTH + 17;
    localparam int LEN_W     = $clog2(MAX_LENGTH + 1);
    localparam int IDX_W     = $clog2(MAX_LENGTH);

    localparam logic [MAX_LENGTH+7:0] LOAD_EXT = {{MAX_LENGTH{1'b0}}, mdsr_pkg::LOAD_PATTERN};
    localparam logic [CNT_W-1:0]      CNT_LAST = CNT_W'(DIV_STEPS - 1);
    localparam logic [5:0]            LEN_HI   = 6'(MAX_LENGTH);

    // configuration registers
    logic [4:0]         r_step_length;
    logic [31:0]        r_flip_threshold;
    logic [2:0]         r_octave_count;
    logic [3:0]         r_scale_degree_count;
    logic signed [15:0] r_output_level;

    // sequencer state
    logic [MAX_LENGTH-1:0] r_pattern;
    logic [31:0]           r_gen;
    logic                  r_clk_seen;
    logic                  r_rst_seen;
    logic                  r_edge;
    mdsr_pkg::t_pc         r_pc;
    mdsr_pkg::t_pc         n_pc;
    logic [CNT_W-1:0]      r_cnt;

    // datapath registers
    logic [5:0]                r_span;
    logic signed [PROD_W-1:0]  r_prod;
    logic [DIVR_W-1:0]         r_rem;
    logic [DIVR_W-1:0]         r_div;
    logic [DIV_STEPS-1:0]      r_quo;
    logic [5:0]                r_degree;
    logic [15:0]               r_frac;
    logic                      r_cv_neg;
    logic [MAG_W-1:0]          r_cv_mag;

    // output register
    logic                      r_out_valid;
    logic [15:0]               r_out_bits;
    logic [5:0]                r_out_degree;
    logic signed [15:0]        r_out_gate;
    logic signed [15:0]        r_out_trig;
    logic signed [15:0]        r_out_cv;
    logic [15:0]               r_out_frac;

    // combinational signals
    mdsr_pkg::t_ucode          c_word;
    logic                      go;
    logic [5:0]                len_ext;
    logic [5:0]                len_cl;
    logic [LEN_W-1:0]          len;
    logic [LEN_W-1:0]          len_dec;
    logic [IDX_W-1:0]          top_idx;
    logic [MAX_LENGTH-1:0]     mask;
    logic [MAX_LENGTH-1:0]     reg_m;
    logic [31:0]               reg_ext;
    logic [31:0]               x1;
    logic [31:0]               x2;
    logic [31:0]               x3;
    logic [31:0]               draw;
    logic                      top_bit;
    logic                      new_bit;
    logic [MAX_LENGTH-1:0]     rot;
    logic [3:0]                cls;
    logic [2:0]                oct;
    logic [5:0]                span;
    logic signed [DIFF_W-1:0]  diff;
    logic signed [PROD_W-1:0]  prod;
    logic [PROD_W-1:0]         mag_full;
    logic [5:0]                deg_c;
    logic [5:0]                fdiv;
    logic [NUM_W-1:0]          start_num;
    logic [NUM_W-1:0]          start_sh;
    logic [DIVR_W-1:0]         start_den;
    logic [DIVR_W:0]           shifted;
    logic [DIVR_W:0]           sub;
    logic                      fits;
    logic [DIVR_W-1:0]         rem_next;
    logic [15:0]               q16;
    logic signed [15:0]        cv_val;

    // control word of the current step
    assign c_word     = mdsr_pkg::ucode_rom(r_pc);
    assign o_in_ready = (c_word.cond == mdsr_pkg::C_WAIT_IN);

    // step condition
    always_comb begin
        case (c_word.cond)
            mdsr_pkg::C_WAIT_IN:  go = i_in_valid;
            mdsr_pkg::C_WAIT_OUT: go = !r_out_valid || i_out_ready;
            default:              go = 1'b1;
        endcase
    end

    // next step
    always_comb begin
        case (c_word.cond)
            mdsr_pkg::C_WAIT_IN,
            mdsr_pkg::C_WAIT_OUT: n_pc = go ? c_word.target : r_pc;
            mdsr_pkg::C_LOOP:     n_pc = (r_cnt == CNT_LAST) ? r_pc + 4'd1 : c_word.target;
            default:              n_pc = c_word.target;
        endcase
    end

    // step length clamp and mask
    always_comb begin
        len_ext = {1'b0, r_step_length};
        if (len_ext < 6'd2) begin
            len_cl = 6'd2;
        end else if (len_ext > LEN_HI) begin
            len_cl = LEN_HI;
        end else begin
            len_cl = len_ext;
        end
        len     = len_cl[LEN_W-1:0];
        len_dec = len - LEN_W'(1);
        top_idx = len_dec[IDX_W-1:0];
        for (int i = 0; i < MAX_LENGTH; i++) begin
            mask[i] = (LEN_W'(i) < len);
        end
    end

    assign reg_m   = r_pattern & mask;
    assign reg_ext = 32'(reg_m);

    // xorshift32 draw and rotation
    assign x1      = r_gen ^ (r_gen << 13);
    assign x2      = x1 ^ (x1 >> 17);
    assign x3      = x2 ^ (x2 << 5);
    assign draw    = (x3 == 32'd0) ? 32'd1 : x3;
    assign top_bit = r_pattern[top_idx];
    assign new_bit = (draw < r_flip_threshold) ? ~top_bit : top_bit;
    assign rot     = {r_pattern[MAX_LENGTH-2:0], new_bit} & mask;

    // degree span
    assign cls  = (r_scale_degree_count > mdsr_pkg::CLASS_MAX) ? mdsr_pkg::CLASS_MAX
                                                                : r_scale_degree_count;
    assign oct  = (r_octave_count > mdsr_pkg::OCT_MAX) ? mdsr_pkg::OCT_MAX : r_octave_count;
    assign span = 6'(cls * (oct + 3'd1));

    // cv product: level * (2*reg - mask)
    assign diff = signed'({1'b0, reg_m, 1'b0}) - signed'({2'b00, mask});
    assign prod = PROD_W'(r_output_level) * PROD_W'(diff);

    // degree and fraction divisor
    assign deg_c    = (r_span == 6'd0) ? 6'd0 : r_rem[5:0];
    assign fdiv     = (r_span > 6'd1) ? r_span - 6'd1 : 6'd1;
    assign mag_full = r_prod[PROD_W-1] ? PROD_W'(-r_prod) : PROD_W'(r_prod);

    // divider start operands
    always_comb begin
        case (c_word.op)
            mdsr_pkg::OP_MUL: begin
                start_num = NUM_W'(reg_m);
                start_den = (span == 6'd0) ? DIVR_W'(1) : DIVR_W'(span);
            end
            mdsr_pkg::OP_MOD_END: begin
                start_num = (NUM_W'(deg_c) << 17) - (NUM_W'(deg_c) << 1) + NUM_W'(fdiv);
                start_den = DIVR_W'({fdiv, 1'b0});
            end
            default: begin
                start_num = (NUM_W'(r_cv_mag) << 1) + NUM_W'(mask);
                start_den = DIVR_W'({mask, 1'b0});
            end
        endcase
        start_sh = start_num >> DIV_STEPS;
    end

    // one restoring divide step
    assign shifted  = {r_rem, r_quo[DIV_STEPS-1]};
    assign sub      = shifted - {1'b0, r_div};
    assign fits     = (shifted >= {1'b0, r_div});
    assign rem_next = fits ? sub[DIVR_W-1:0] : shifted[DIVR_W-1:0];

    // cv rounding result with saturation
    assign q16    = r_quo[15:0];
    assign cv_val = r_cv_neg ? signed'(16'd0 - q16)
                             : (q16[15] ? 16'sh7FFF : signed'(q16));

    // sequencer and control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pc        <= mdsr_pkg::STEP_LATCH;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_pc <= n_pc;
            if (c_word.op == mdsr_pkg::OP_DIV) begin
                r_cnt <= r_cnt + CNT_W'(1);
            end else begin
                r_cnt <= '0;
            end
            if (c_word.op == mdsr_pkg::OP_OUT && go) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // configuration, edge flags, pattern and generator
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step_length        <= mdsr_pkg::STEP_LENGTH_RST;
            r_flip_threshold     <= '0;
            r_octave_count       <= '0;
            r_scale_degree_count <= mdsr_pkg::CLASS_COUNT_RST;
            r_output_level       <= mdsr_pkg::LEVEL_RST;
            r_pattern            <= LOAD_EXT[MAX_LENGTH-1:0];
            r_gen                <= mdsr_pkg::GEN_RST;
            r_clk_seen           <= 1'b0;
            r_rst_seen           <= 1'b0;
            r_edge               <= 1'b0;
        end else begin
            // transaction accepted: edge detect and reset load
            if (c_word.op == mdsr_pkg::OP_LATCH && go) begin
                if (i_reset_high && !r_rst_seen) begin
                    r_pattern <= LOAD_EXT[MAX_LENGTH-1:0] & mask;
                end
                r_rst_seen <= i_reset_high;
                r_edge     <= i_clock_high && !r_clk_seen;
                r_clk_seen <= i_clock_high;
            end
            // rotate on a clock edge
            if (c_word.op == mdsr_pkg::OP_ROTATE && r_edge) begin
                r_pattern <= rot;
                r_gen     <= draw;
            end
            // register writes
            if (i_cfg_wr_en) begin
                case (mdsr_pkg::t_cfg_idx'(i_cfg_addr))
                    mdsr_pkg::CFG_STEP_LENGTH:        r_step_length <= i_cfg_wdata[4:0];
                    mdsr_pkg::CFG_FLIP_THRESHOLD:     r_flip_threshold <= i_cfg_wdata;
                    mdsr_pkg::CFG_OCTAVE_COUNT:       r_octave_count <= i_cfg_wdata[2:0];
                    mdsr_pkg::CFG_SCALE_DEGREE_COUNT: r_scale_degree_count <= i_cfg_wdata[3:0];
                    mdsr_pkg::CFG_OUTPUT_LEVEL:       r_output_level <= signed'(i_cfg_wdata[15:0]);
                    mdsr_pkg::CFG_SEED_VALUE: begin
                        r_gen     <= (i_cfg_wdata == 32'd0) ? 32'd1 : i_cfg_wdata;
                        r_pattern <= LOAD_EXT[MAX_LENGTH-1:0];
                    end
                    default: ;
                endcase
            end
        end
    end

    // datapath
    always_ff @(posedge i_clk) begin
        case (c_word.op)
            mdsr_pkg::OP_MUL: begin
                r_span <= span;
                r_prod <= prod;
                r_rem  <= DIVR_W'(start_sh);
                r_quo  <= start_num[DIV_STEPS-1:0];
                r_div  <= start_den;
            end
            mdsr_pkg::OP_DIV: begin
                r_rem <= rem_next;
                r_quo <= {r_quo[DIV_STEPS-2:0], fits};
            end
            mdsr_pkg::OP_MOD_END: begin
                r_degree <= deg_c;
                r_rem    <= DIVR_W'(start_sh);
                r_quo    <= start_num[DIV_STEPS-1:0];
                r_div    <= start_den;
            end
            mdsr_pkg::OP_FRAC_END: begin
                r_frac   <= q16;
                r_cv_neg <= r_prod[PROD_W-1];
                r_cv_mag <= mag_full[MAG_W-1:0];
            end
            mdsr_pkg::OP_CV_START: begin
                r_rem <= DIVR_W'(start_sh);
                r_quo <= start_num[DIV_STEPS-1:0];
                r_div <= start_den;
            end
            default: ;
        endcase
    end

    // output register load
    always_ff @(posedge i_clk) begin
        if (c_word.op == mdsr_pkg::OP_OUT && go) begin
            r_out_bits   <= reg_ext[15:0];
            r_out_degree <= r_degree;
            r_out_gate   <= reg_m[0] ? r_output_level : 16'sd0;
            r_out_trig   <= r_edge ? r_output_level : 16'sd0;
            r_out_cv     <= cv_val;
            r_out_frac   <= r_frac;
        end
    end

    assign o_out_valid       = r_out_valid;
    assign o_register_bits   = r_out_bits;
    assign o_scale_degree    = r_out_degree;
    assign o_gate_value      = r_out_gate;
    assign o_trigger_value   = r_out_trig;
    assign o_bipolar_cv      = r_out_cv;
    assign o_degree_fraction = r_out_frac;

    // checks
    `ASSERT_PROP(a_accept_starts_program, i_clk, i_rst_n, (i_in_valid && o_in_ready) |=> (r_pc == mdsr_pkg::STEP_ROTATE), "accepted transaction did not start the program")
    `ASSERT_PROP(a_rem_below_divisor, i_clk, i_rst_n, (c_word.op == mdsr_pkg::OP_DIV) |-> (r_rem < r_div), "divider remainder not below divisor")
    `ASSERT_PROP(a_out_from_out_step, i_clk, i_rst_n, $rose(r_out_valid) |-> ($past(r_pc) == mdsr_pkg::STEP_OUT), "output valid rose outside the output step")
    `ASSERT_PROP(a_div_count_starts_zero, i_clk, i_rst_n, ((c_word.op == mdsr_pkg::OP_DIV) && ($past(c_word.op) != mdsr_pkg::OP_DIV)) |-> (r_cnt == '0), "divide loop started with nonzero count")

endmodule
